/* hw/rtl/bsfp4q_pkg.sv */
// ---------------------------------------------------------------------------
// bsfp4q_pkg
// Shared types and constants of the block scaled fp4 quantizer.
// ---------------------------------------------------------------------------
package bsfp4q_pkg;

   localparam int BLOCK_MAX = 16;
   localparam int IDX_W     = $clog2(BLOCK_MAX);
   localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
   localparam int STEP_W    = 6;
   localparam int NUM_THR   = 4;

   // reciprocal of three for a 24-bit mantissa, and the fraction of 2^26/3, 2^27/3
   localparam logic [23:0] RECIP_3     = 24'hAA_AAAB;
   localparam logic [25:0] THIRD_FRAC1 = 26'h155_5555;
   localparam logic [25:0] THIRD_FRAC2 = 26'h2AA_AAAA;

   // 1e-9 and +inf in single precision
   localparam logic [31:0] SCALE_ADD = 32'h3089_705F;
   localparam logic [31:0] SCALE_INF = 32'h7F80_0000;
   localparam logic [7:0]  ADD_EXP   = 8'd97;
   localparam logic [23:0] ADD_MANT  = 24'h89_705F;
   // below this exponent a/3 vanishes against 1e-9
   localparam logic [7:0]  SMALL_EXP = 8'd73;

   // rounding midpoints above 2^-27, 0.375, 0.75, 1.5 as odd mantissa and shift
   localparam logic [24:0] MID_MANT [NUM_THR] =
      '{25'h100_0001, 25'h180_0001, 25'h180_0001, 25'h180_0001};
   localparam logic [5:0]  MID_SHIFT [NUM_THR] = '{6'd51, 6'd26, 6'd25, 6'd24};

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] block_scale;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic             store;
      logic [IDX_W-1:0] wr_idx;
      logic             clear;
      logic             div_init;
      logic             div_step;
      logic             do_third;
      logic             do_scale;
      logic             prod_en;
      logic [1:0]       thr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             cmp_en;
      logic             out_load;
      logic             out_last;
   } dp_cmd_type;

endpackage

/* hw/rtl/bsfp4q_datapath.sv */
// ---------------------------------------------------------------------------
// bsfp4q_datapath
// Value store, running maximum, scale arithmetic and code decision.
// ---------------------------------------------------------------------------
module bsfp4q_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bsfp4q_pkg::dp_cmd_type cmd,
   input  bsfp4q_pkg::req_type   req_payload,
   output bsfp4q_pkg::rsp_type   rsp_payload
);

   logic [31:0] mem [bsfp4q_pkg::BLOCK_MAX];
   logic [30:0] amax_ff;
   logic [47:0] recip_ff;
   logic [49:0] quo_ff;
   logic [1:0]  rem_ff;
   logic [7:0]  third_exp_ff;
   logic [23:0] third_man_ff;
   logic [31:0] scale_ff;
   logic [48:0] prod_ff [bsfp4q_pkg::NUM_THR];
   logic [31:0] x_ff;
   logic [2:0]  k_ff;
   bsfp4q_pkg::rsp_type rsp_ff;

   // store and running maximum
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[cmd.wr_idx] <= req_payload.sample_bits;
      end
      if (cmd.rd_en) begin
         x_ff <= mem[cmd.rd_idx];
      end
   end

   logic [30:0] abs_in;
   assign abs_in = req_payload.sample_bits[30:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         amax_ff <= '0;
      end else if (cmd.store && abs_in <= 31'h7F80_0000 && abs_in > amax_ff) begin
         amax_ff <= abs_in;
      end
   end

   // divide by three, reciprocal product then remainder fix
   logic [23:0] div_m;
   logic [22:0] div_q0;
   logic [23:0] div_3q;
   logic [1:0]  div_r;
   logic [25:0] div_frac;
   always_comb begin
      div_m  = {1'b1, amax_ff[22:0]};
      div_q0 = recip_ff[47:25];
      div_3q = {div_q0, 1'b0} + {1'b0, div_q0};
      div_r  = 2'(div_m - div_3q);
      case (div_r)
         2'd1:    div_frac = bsfp4q_pkg::THIRD_FRAC1;
         2'd2:    div_frac = bsfp4q_pkg::THIRD_FRAC2;
         default: div_frac = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         recip_ff <= div_m * bsfp4q_pkg::RECIP_3;
      end else if (cmd.div_step) begin
         quo_ff <= {1'b0, div_q0, div_frac};
         rem_ff <= div_r;
      end
   end

   // round the third
   logic [23:0] th_m;
   logic        th_g;
   logic        th_s;
   logic [7:0]  th_e;
   logic [24:0] th_r;
   always_comb begin
      if (quo_ff[48]) begin
         th_m = quo_ff[48:25];
         th_g = quo_ff[24];
         th_s = (|quo_ff[23:0]) | (|rem_ff);
         th_e = 8'(amax_ff[30:23] - 8'd1);
      end else begin
         th_m = quo_ff[47:24];
         th_g = quo_ff[23];
         th_s = (|quo_ff[22:0]) | (|rem_ff);
         th_e = 8'(amax_ff[30:23] - 8'd2);
      end
      th_r = {1'b0, th_m} + 25'(th_g & (th_s | th_m[0]));
   end

   always_ff @(posedge clock) begin
      if (cmd.do_third) begin
         if (th_r[24]) begin
            third_exp_ff <= 8'(th_e + 8'd1);
            third_man_ff <= 24'h80_0000;
         end else begin
            third_exp_ff <= th_e;
            third_man_ff <= th_r[23:0];
         end
      end
   end

   // third plus 1e-9
   logic [7:0]   ad_eb;
   logic [23:0]  ad_mb;
   logic [23:0]  ad_ms;
   logic [7:0]   ad_d;
   logic [100:0] ad_sh;
   logic [49:0]  ad_al;
   logic         ad_stk;
   logic [50:0]  ad_sum;
   logic [23:0]  ad_m;
   logic         ad_g;
   logic         ad_s;
   logic [8:0]   ad_e;
   logic [24:0]  ad_r;
   logic [31:0]  ad_res;
   always_comb begin
      if (third_exp_ff >= bsfp4q_pkg::ADD_EXP) begin
         ad_eb = third_exp_ff;
         ad_mb = third_man_ff;
         ad_ms = bsfp4q_pkg::ADD_MANT;
         ad_d  = 8'(third_exp_ff - bsfp4q_pkg::ADD_EXP);
      end else begin
         ad_eb = bsfp4q_pkg::ADD_EXP;
         ad_mb = bsfp4q_pkg::ADD_MANT;
         ad_ms = third_man_ff;
         ad_d  = 8'(bsfp4q_pkg::ADD_EXP - third_exp_ff);
      end
      ad_sh = {ad_ms, 77'b0} >> ad_d[5:0];
      if (ad_d > 8'd50) begin
         ad_al  = '0;
         ad_stk = 1'b1;
      end else begin
         ad_al  = ad_sh[100:51];
         ad_stk = |ad_sh[50:0];
      end
      ad_sum = {1'b0, ad_mb, 26'b0} + {1'b0, ad_al};
      if (ad_sum[50]) begin
         ad_m = ad_sum[50:27];
         ad_g = ad_sum[26];
         ad_s = (|ad_sum[25:0]) | ad_stk;
         ad_e = {1'b0, ad_eb} + 9'd1;
      end else begin
         ad_m = ad_sum[49:26];
         ad_g = ad_sum[25];
         ad_s = (|ad_sum[24:0]) | ad_stk;
         ad_e = {1'b0, ad_eb};
      end
      ad_r = {1'b0, ad_m} + 25'(ad_g & (ad_s | ad_m[0]));
      if (ad_r[24]) begin
         ad_res = {1'b0, 8'(ad_e + 9'd1), 23'b0};
      end else begin
         ad_res = {1'b0, ad_e[7:0], ad_r[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_scale) begin
         if (amax_ff[30:23] == 8'hFF) begin
            scale_ff <= bsfp4q_pkg::SCALE_INF;
         end else if (amax_ff[30:23] < bsfp4q_pkg::SMALL_EXP) begin
            scale_ff <= bsfp4q_pkg::SCALE_ADD;
         end else begin
            scale_ff <= ad_res;
         end
      end
   end

   // midpoint times scale, one threshold a cycle
   always_ff @(posedge clock) begin
      if (cmd.prod_en) begin
         prod_ff[cmd.thr] <= bsfp4q_pkg::MID_MANT[cmd.thr] * {1'b1, scale_ff[22:0]};
      end
   end

   // compare |x| against midpoint times scale
   logic [7:0]         cx_e;
   logic [23:0]        cx_m;
   logic signed [10:0] cx_d;
   logic [6:0]         cx_sh;
   logic [96:0]        cx_l;
   logic [96:0]        cx_r;
   logic               cx_gt;
   always_comb begin
      cx_e  = (x_ff[30:23] == 8'd0) ? 8'd1 : x_ff[30:23];
      cx_m  = {(x_ff[30:23] != 8'd0), x_ff[22:0]};
      cx_d  = $signed({3'b0, cx_e}) - $signed({3'b0, scale_ff[30:23]})
            + $signed({5'b0, bsfp4q_pkg::MID_SHIFT[cmd.thr]});
      cx_sh = 7'(cx_d + 11'sd24);
      cx_l  = 97'(cx_m) << cx_sh;
      cx_r  = {24'b0, prod_ff[cmd.thr], 24'b0};
      if (cx_d >= 11'sd49) begin
         cx_gt = (cx_m != 24'd0);
      end else if (cx_d <= -11'sd24) begin
         cx_gt = 1'b0;
      end else begin
         cx_gt = (cx_l > cx_r);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         k_ff <= '0;
      end else if (cmd.cmp_en && cx_gt) begin
         k_ff <= 3'(k_ff + 3'd1);
      end
   end

   // code from sign and bucket
   logic [2:0] code_in;
   always_comb begin
      if (scale_ff[30:23] == 8'hFF) begin
         code_in = 3'd0;
      end else if (x_ff[30:23] == 8'hFF) begin
         code_in = (x_ff[22:0] != 23'd0) ? 3'd0 : (x_ff[31] ? 3'd7 : 3'd3);
      end else if (x_ff[31]) begin
         code_in = (k_ff == 3'd0) ? 3'd0 : 3'(k_ff + 3'd3);
      end else begin
         code_in = (k_ff <= 3'd1) ? 3'd0 : 3'(k_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.code        <= code_in;
         rsp_ff.block_scale <= scale_ff;
         rsp_ff.last_out    <= cmd.out_last;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/bsfp4q_control.sv */
// ---------------------------------------------------------------------------
// bsfp4q_control
// Sequencer for block load, scale computation and per-word replay.
// ---------------------------------------------------------------------------
module bsfp4q_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bsfp4q_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_INIT, S_DIV, S_THIRD, S_SCALE, S_PROD, S_READ, S_CMP, S_FORM, S_EMIT
   } state_type;

   state_type                        state_ff;
   logic [bsfp4q_pkg::CNT_W-1:0]     fill_ff;
   logic [bsfp4q_pkg::CNT_W-1:0]     count_ff;
   logic [bsfp4q_pkg::IDX_W-1:0]     idx_ff;
   logic [bsfp4q_pkg::STEP_W-1:0]    step_ff;
   logic                             rsp_valid_ff;

   logic                             accept;
   logic [bsfp4q_pkg::CNT_W-1:0]     fill_in;
   logic                             is_last;

   assign accept  = req_valid && (state_ff == S_LOAD);
   assign fill_in = bsfp4q_pkg::CNT_W'(fill_ff + 1'b1);
   assign is_last = (bsfp4q_pkg::CNT_W'(idx_ff) + 1'b1) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  fill_ff <= fill_in;
                  if (req_last || fill_in == bsfp4q_pkg::CNT_W'(bsfp4q_pkg::BLOCK_MAX)) begin
                     count_ff <= fill_in;
                     state_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_THIRD;
            end
            S_THIRD: begin
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               step_ff  <= '0;
               state_ff <= S_PROD;
            end
            S_PROD: begin
               step_ff <= bsfp4q_pkg::STEP_W'(step_ff + 1'b1);
               if (step_ff[1:0] == 2'd3) begin
                  idx_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               step_ff  <= '0;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               step_ff <= bsfp4q_pkg::STEP_W'(step_ff + 1'b1);
               if (step_ff[1:0] == 2'd3) begin
                  state_ff <= S_FORM;
               end
            end
            S_FORM: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (is_last) begin
                     fill_ff  <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     idx_ff   <= bsfp4q_pkg::IDX_W'(idx_ff + 1'b1);
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.store    = accept;
      cmd.wr_idx   = fill_ff[bsfp4q_pkg::IDX_W-1:0];
      cmd.clear    = (state_ff == S_EMIT) && !rsp_stall && is_last;
      cmd.div_init = (state_ff == S_INIT);
      cmd.div_step = (state_ff == S_DIV);
      cmd.do_third = (state_ff == S_THIRD);
      cmd.do_scale = (state_ff == S_SCALE);
      cmd.prod_en  = (state_ff == S_PROD);
      cmd.thr      = step_ff[1:0];
      cmd.rd_en    = (state_ff == S_READ);
      cmd.rd_idx   = idx_ff;
      cmd.cmp_en   = (state_ff == S_CMP);
      cmd.out_load = (state_ff == S_FORM);
      cmd.out_last = is_last;
   end

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/block_scaled_fp4_quantizer.sv */
// ---------------------------------------------------------------------------
// block_scaled_fp4_quantizer
// Loading: one word per cycle in the load state. After the closing word the
// scale (reciprocal divide by three) runs through init, divide, third, scale
// and midpoint product states; each code then passes read, compare, form and
// emit, where output stall holds it. Input stalls until the last code leaves.
// Reset: synchronous, clears fill count, running maximum and control state.
// ---------------------------------------------------------------------------
module block_scaled_fp4_quantizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bsfp4q_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bsfp4q_pkg::rsp_type rsp_payload
);

   bsfp4q_pkg::dp_cmd_type cmd;

   bsfp4q_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_last  (req_payload.last_in),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bsfp4q_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the block scaled fp4 quantizer. Blocks of single
// precision words go in; a bit-exact predictor forms the block scale and the
// nearest table code of every word. Each returned word is checked in order,
// under several phases of sender idling and receiver stall.
// ---------------------------------------------------------------------------
class fp4_scoreboard;
   logic [31:0]         held_words [bsfp4q_pkg::BLOCK_MAX];
   int                  held_count;
   logic [31:0]         peak_mag;
   bsfp4q_pkg::rsp_type pending_codes [$];
   int                  fail_count;

   function new();
      held_count = 0;
      peak_mag   = 32'h0;
      fail_count = 0;
   endfunction

   // single bits to real, finite values only
   function real sp_to_real(logic [31:0] b);
      real r;
      if (b[30:23] == 8'd0)
         r = real'(b[22:0]) * 2.0 ** (-149);
      else
         r = $bitstoreal({1'b0, 11'(int'(b[30:23]) + 896), b[22:0], 29'b0});
      if (b[31])
         r = -r;
      return r;
   endfunction

   // round a real to single precision, nearest even
   function logic [31:0] real_to_sp(real r);
      logic [63:0] d;
      logic        sgn;
      int          ue;
      int          se;
      int          drop;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      d   = $realtobits(r);
      sgn = d[63];
      if (d[62:52] == 11'd0)
         return {sgn, 31'b0};
      ue = int'(d[62:52]) - 1023;
      if (ue > 127)
         return {sgn, 8'hFF, 23'b0};
      se   = ue + 127;
      sig  = {11'b0, 1'b1, d[51:0]};
      drop = 29 + ((se < 1) ? 1 - se : 0);
      if (drop > 60)
         return {sgn, 31'b0};
      kept = sig >> drop;
      rem  = sig & ((64'd1 << drop) - 64'd1);
      half = 64'd1 << (drop - 1);
      if (rem > half || (rem == half && kept[0]))
         kept = kept + 64'd1;
      kept = kept + (64'((se >= 1) ? se - 1 : 0) << 23);
      if (kept >= 64'h7F80_0000)
         return {sgn, 8'hFF, 23'b0};
      return {sgn, kept[30:0]};
   endfunction

   function logic [2:0] nearest_level(logic [31:0] x, logic [31:0] scale);
      real         levels [8];
      logic [31:0] v;
      logic [31:0] err;
      logic [31:0] least_err;
      logic [2:0]  best;
      real         vr;
      levels = '{0.25, 0.5, 1.0, 2.0, -0.25, -0.5, -1.0, -2.0};
      // a nan or infinite word, or an infinite scale, lands on code zero
      if (x[30:23] == 8'hFF || scale[30:23] == 8'hFF)
         return 3'd0;
      v  = real_to_sp(sp_to_real(x) / sp_to_real(scale));
      vr = sp_to_real(v);
      if (vr < -3.0)
         vr = -3.0;
      if (vr > 3.0)
         vr = 3.0;
      least_err = 32'h4E6E_6B28;
      best      = 3'd0;
      for (int j = 0; j < 8; j++) begin
         err = real_to_sp(vr - levels[j]) & 32'h7FFF_FFFF;
         if (err < least_err) begin
            least_err = err;
            best      = 3'(j);
         end
      end
      return best;
   endfunction

   function void note_word(bsfp4q_pkg::req_type w);
      logic [31:0]         mag;
      logic [31:0]         scale;
      bsfp4q_pkg::rsp_type r;
      if (held_count >= bsfp4q_pkg::BLOCK_MAX)
         held_count = 0;
      held_words[held_count] = w.sample_bits;
      held_count++;
      mag = w.sample_bits & 32'h7FFF_FFFF;
      if (!(mag[30:23] == 8'hFF && mag[22:0] != 0) && mag > peak_mag)
         peak_mag = mag;
      if (!w.last_in && held_count < bsfp4q_pkg::BLOCK_MAX)
         return;
      if (peak_mag[30:23] == 8'hFF)
         scale = bsfp4q_pkg::SCALE_INF;
      else
         scale = real_to_sp(sp_to_real(real_to_sp(sp_to_real(peak_mag) / 3.0))
                            + sp_to_real(bsfp4q_pkg::SCALE_ADD));
      for (int i = 0; i < held_count; i++) begin
         r.code        = nearest_level(held_words[i], scale);
         r.block_scale = scale;
         r.last_out    = (i == held_count - 1);
         pending_codes.insert(pending_codes.size(), r);
      end
      held_count = 0;
      peak_mag   = 32'h0;
   endfunction

   function void check_word(bsfp4q_pkg::rsp_type got);
      bsfp4q_pkg::rsp_type want;
      if (pending_codes.size() == 0) begin
         $error("unexpected word: code %0d scale %h", got.code, got.block_scale);
         fail_count++;
         return;
      end
      want = pending_codes.pop_front();
      if (got.code !== want.code) begin
         $error("code: expected %0d, got %0d", want.code, got.code);
         fail_count++;
      end
      if (got.block_scale !== want.block_scale) begin
         $error("block_scale: expected %h, got %h", want.block_scale, got.block_scale);
         fail_count++;
      end
      if (got.last_out !== want.last_out) begin
         $error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
         fail_count++;
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 500000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   bsfp4q_pkg::req_type req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   bsfp4q_pkg::rsp_type rsp_payload;

   fp4_scoreboard sb;
   int            idle_pct;
   int            stall_pct;
   int            cycle_count;
   int            random_words;

   block_scaled_fp4_quantizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_payload);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task send_word(logic [31:0] bits, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{sample_bits: bits, last_in: last};
      do
         @(posedge clock);
      while (req_stall);
      sb.note_word('{sample_bits: bits, last_in: last});
   endtask

   function logic [31:0] pick_value(int base_exp);
      logic [31:0] b;
      int          e;
      int          kind;
      kind = $urandom_range(0, 39);
      b    = $urandom;
      case (kind)
         0, 1, 2: ;
         3: b = {b[31], 31'b0};
         4: b = {b[31], 8'd0, b[22:0]};
         5: b = {b[31], 8'hFF, 22'b0, 1'b1} | (b & 32'h003F_FFFF);
         6: if ($urandom_range(0, 3) == 0) b = {b[31], 8'hFF, 23'b0};
         default: begin
            e = base_exp - int'($urandom_range(0, 6));
            if (e < 1)
               e = 1;
            b[30:23] = 8'(e);
            // few mantissa bits make ties between levels likely
            if (kind < 20)
               b[22:0] = b[22:0] & 23'h70_0000;
         end
      endcase
      return b;
   endfunction

   task send_block(int len, int base_exp);
      for (int i = 0; i < len; i++)
         send_word(pick_value(base_exp), (i == len - 1));
   endtask

   task random_phase(int words, int idle, int stall);
      int len;
      idle_pct  = idle;
      stall_pct = stall;
      random_words = 0;
      while (random_words < words) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, bsfp4q_pkg::BLOCK_MAX)
                                           : $urandom_range(1, 6);
         if ($urandom_range(0, 7) == 0) begin
            // no closing flag: the store fills and closes on its own
            for (int i = 0; i < bsfp4q_pkg::BLOCK_MAX; i++)
               send_word(pick_value(int'($urandom_range(1, 254))), 1'b0);
            random_words += bsfp4q_pkg::BLOCK_MAX;
         end else begin
            send_block(len, int'($urandom_range(1, 254)));
            random_words += len;
         end
      end
   endtask

   initial begin
      sb          = new();
      cycle_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(32'h0000_0000, 1'b1);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7F7F_FFFF, 1'b0);
      send_word(32'hFF7F_FFFF, 1'b0);
      send_word(32'h3F80_0000, 1'b0);
      send_word(32'h8000_0001, 1'b1);
      send_word(32'h7F80_0000, 1'b0);
      send_word(32'h4000_0000, 1'b0);
      send_word(32'hBF80_0000, 1'b1);
      send_word(32'h7FC0_0000, 1'b0);
      send_word(32'h4040_0000, 1'b0);
      send_word(32'hC000_0000, 1'b1);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h807F_FFFF, 1'b1);
      send_word(32'h3000_0000, 1'b0);
      send_word(32'hB200_0000, 1'b1);
      for (int i = 0; i < bsfp4q_pkg::BLOCK_MAX; i++)
         send_word(32'h3E80_0000 + 32'(i) * 32'h0010_0000 | (32'(i & 1) << 31), 1'b0);

      random_phase(33, 0, 0);
      random_phase(33, 49, 0);
      random_phase(33, 0, 49);
      random_phase(33, 13, 13);
      req_valid <= 1'b0;

      while (sb.pending_codes.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
